>>> rtl/vg3_pkg.sv
`timescale 1ns / 1ps
// Package for the vertical gradient 3x3 filter: field widths, register indexes,
// kernel weights and the structs passed between the filter's modules. No dependencies.
package vg3_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;
  localparam int TDATA_OUT_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Reset value of both size registers and the smallest frame dimension allowed.
  localparam int CFG_RESET = 1024;
  localparam int MIN_SIZE  = 3;

  // Kernel rows are -3,-1,-3 / 0,0,0 / 3,1,3.
  localparam int KW_SIDE = 3;
  localparam int SUM_W   = 11;
  localparam int PIX_MAX = 255;

  // Neighbourhood of the pixel at column c-1: far is column c-2, near is column c-1.
  typedef struct packed {
    logic [PIX_W-1:0] top_far;
    logic [PIX_W-1:0] top_near;
    logic [PIX_W-1:0] mid_near;
    logic [PIX_W-1:0] bot_far;
    logic [PIX_W-1:0] bot_near;
  } window_t;

  typedef struct packed {
    logic               last_frame;
    logic               last_item;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pixel;
  } result_t;

endpackage

>>> rtl/vg3_line_ram.sv
`timescale 1ns / 1ps
// One line store: a simple dual-port synchronous RAM with registered read data.
// Uses no package.
module vg3_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read data holds while no new read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/vg3_kernel.sv
`timescale 1ns / 1ps
// Kernel arithmetic for one output pixel, clamped to the pixel range.
// Depends on vg3_pkg.
module vg3_kernel
  import vg3_pkg::*;
(
  input  window_t          win,
  input  logic [PIX_W-1:0] top,
  input  logic [PIX_W-1:0] pix,
  input  logic             col_is_one,
  output logic [PIX_W-1:0] value
);

  logic [PIX_W:0]   pos_pair;
  logic [PIX_W:0]   neg_pair;
  logic [SUM_W-1:0] pos_sum;
  logic [SUM_W-1:0] neg_sum;
  logic [SUM_W-1:0] diff;

  assign pos_pair = {1'b0, win.bot_far} + {1'b0, pix};
  assign neg_pair = {1'b0, win.top_far} + {1'b0, top};
  assign pos_sum  = SUM_W'(KW_SIDE) * SUM_W'(pos_pair) + SUM_W'(win.bot_near);
  assign neg_sum  = SUM_W'(KW_SIDE) * SUM_W'(neg_pair) + SUM_W'(win.top_near);
  assign diff     = pos_sum - neg_sum;

  // Column 0 is a border column, so the pixel at column 0 of the row above passes through.
  always_comb begin
    if (col_is_one) begin
      value = win.mid_near;
    end else if (neg_sum >= pos_sum) begin
      value = '0;
    end else if (diff > SUM_W'(PIX_MAX)) begin
      value = PIX_W'(PIX_MAX);
    end else begin
      value = diff[PIX_W-1:0];
    end
  end

endmodule

>>> rtl/vg3_out_fifo.sv
`timescale 1ns / 1ps
// Two-entry result queue that decouples result generation from the output stream.
// Depends on vg3_pkg.
module vg3_out_fifo
  import vg3_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    head_valid,
  input  logic    pop,
  output result_t head
);

  result_t     slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign can_push   = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && can_push;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> rtl/vertical_gradient_3x3_filter.sv
`timescale 1ns / 1ps
// Top level of the vertical gradient 3x3 filter: counters, line store control and result
// sequencing. Depends on vg3_pkg, vg3_line_ram, vg3_kernel and vg3_out_fifo.
//
// Pixels arrive in raster order on the s_axis request channel, one 8-bit pixel per request.
// Each interior pixel is replaced by the kernel -3,-1,-3 / 0,0,0 / 3,1,3 clamped to 0..255;
// the border rows and columns pass through unchanged. Results leave on m_axis carrying the
// pixel value with its row and column; tuser marks the last result caused by one input
// pixel and tlast the last result of the frame.
// Frame size is set through cfg_we/cfg_index/cfg_data (index 0 width, index 1 height),
// and values are saturated to the range 3 up to the maximum size on write. Write them
// only while no request is in flight.
// An accepted pixel reads both line stores at its column as it is taken; its first result
// is then formed from the registered pixel and pushed into a two-entry output queue,
// whose head drives m_axis. A pixel with one result or none lets the next pixel in as it
// retires, so an ordinary row flows at one pixel per clock while the output queue has room.
// A pixel with more results is held by the single push port into the output queue: a
// pixel of the last row past its first column, or at the right edge of a row from the
// third on, causes two results (the last pixel of the frame three) and keeps
// s_axis_tready low until the cycle that pushes its last result.
// Reset clears the counters, the window and the queue and sets both sizes to 1024 (or
// the maximum if smaller); the line stores need no clearing. When the receiver stalls,
// the queue fills, the pixel in flight waits and s_axis_tready drops.
module vertical_gradient_3x3_filter
  import vg3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input pixels. tdata: pixel [7:0].
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [PIX_W-1:0]       s_axis_tdata,
  // Results. tdata: out_pixel [7:0], out_row [17:8], out_col [27:18], zeros above.
  // tuser: last_of_item. tlast: last_of_frame.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast,
  // Configuration writes.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WCMP = ((CFG_W > CW) ? CFG_W : CW) + 1;
  localparam int HCMP = ((CFG_W > RW) ? CFG_W : RW) + 1;
  localparam int W_RESET = (CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET;
  localparam int H_RESET = (CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET;
  localparam int PAD_W = TDATA_OUT_W - PIX_W - 2 * COORD_W;

  // Sizes are held as the index of the last column and the last row.
  logic [CW-1:0]   w_last;
  logic [RW-1:0]   h_last;
  logic [CW-1:0]   w_last_cfg;
  logic [RW-1:0]   h_last_cfg;
  logic [WCMP-1:0] cfg_ext_w;
  logic [HCMP-1:0] cfg_ext_h;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count_next;
  logic [RW-1:0] row_count_next;
  logic [CW-1:0] col0;
  logic [RW-1:0] row0;
  logic [2:0]    mask0;

  logic               accept;
  logic               s1_valid;
  logic [2:0]         s1_pending;
  logic [CW-1:0]      s1_col;
  logic [RW-1:0]      s1_row;
  logic [PIX_W-1:0]   s1_pix;
  logic               s1_frame_end;
  logic [PIX_W-1:0]   top_rd;
  logic [PIX_W-1:0]   mid_rd;

  window_t          win;
  logic [PIX_W-1:0] kern_value;
  logic [2:0]       lowest;
  logic [2:0]       rest;
  result_t          res;
  logic             fifo_can_push;
  logic             push;
  logic             done;
  logic             fifo_valid;
  result_t          head;

  // ---------------------------------------------------------------- configuration
  assign cfg_ext_w = WCMP'(cfg_data);
  assign cfg_ext_h = HCMP'(cfg_data);

  always_comb begin
    if (cfg_ext_w < WCMP'(MIN_SIZE)) begin
      w_last_cfg = CW'(MIN_SIZE - 1);
    end else if (cfg_ext_w > WCMP'(MAX_WIDTH)) begin
      w_last_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_cfg = CW'(cfg_ext_w - WCMP'(1));
    end
    if (cfg_ext_h < HCMP'(MIN_SIZE)) begin
      h_last_cfg = RW'(MIN_SIZE - 1);
    end else if (cfg_ext_h > HCMP'(MAX_HEIGHT)) begin
      h_last_cfg = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last_cfg = RW'(cfg_ext_h - HCMP'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= CW'(W_RESET - 1);
      h_last <= RW'(H_RESET - 1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  w_last <= w_last_cfg;
        REG_IMAGE_HEIGHT: h_last <= h_last_cfg;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- position of the new pixel
  // After the size shrinks the stored position may lie outside the frame; it then moves
  // to the start of the next row, and a row beyond the frame wraps to row 0.
  always_comb begin
    if (col_count > w_last) begin
      col0 = '0;
      row0 = (row_count >= h_last) ? '0 : row_count + RW'(1);
    end else begin
      col0 = col_count;
      row0 = (row_count > h_last) ? '0 : row_count;
    end
    if (col0 == w_last) begin
      col_count_next = '0;
      row_count_next = (row0 == h_last) ? '0 : row0 + RW'(1);
    end else begin
      col_count_next = col0 + CW'(1);
      row_count_next = row0;
    end
  end

  // Bit 0: interior or left-border pixel of the row above; bit 1: right border pixel of the row above;
  // bit 2: the pixel itself on the first or last row.
  assign mask0[0] = (row0 >= RW'(2)) && (col0 != '0);
  assign mask0[1] = (row0 >= RW'(2)) && (col0 == w_last);
  assign mask0[2] = (row0 == '0) || (row0 == h_last);

  assign s_axis_tready = !rst && (!s1_valid || done);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ---------------------------------------------------------------- line stores
  // The pixel in flight writes its column as it retires, while the next pixel reads the
  // following column. Consecutive pixels never share a column, so no forwarding is needed.
  vg3_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIX_W)) u_line_prev (
    .clk   (clk),
    .we    (done),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (col0),
    .rdata (mid_rd)
  );

  vg3_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIX_W)) u_line_two_back (
    .clk   (clk),
    .we    (done),
    .waddr (s1_col),
    .wdata (mid_rd),
    .re    (accept),
    .raddr (col0),
    .rdata (top_rd)
  );

  // ---------------------------------------------------------------- pixel in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col       <= col0;
      s1_row       <= row0;
      s1_pix       <= s_axis_tdata;
      s1_frame_end <= (row0 == h_last) && (col0 == w_last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s1_pending <= '0;
    end else if (accept) begin
      s1_valid   <= 1'b1;
      s1_pending <= mask0;
    end else begin
      if (done) begin
        s1_valid <= 1'b0;
      end
      if (push) begin
        s1_pending <= rest;
      end
    end
  end

  // Window columns c-2 and c-1 of the three rows; the middle row only needs c-1.
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (done) begin
      win.top_far  <= win.top_near;
      win.top_near <= top_rd;
      win.mid_near <= mid_rd;
      win.bot_far  <= win.bot_near;
      win.bot_near <= s1_pix;
    end
  end

  vg3_kernel u_kernel (
    .win        (win),
    .top        (top_rd),
    .pix        (s1_pix),
    .col_is_one (s1_col == CW'(1)),
    .value      (kern_value)
  );

  // ---------------------------------------------------------------- result sequencing
  // Pending results go out lowest bit first, one per cycle while the output queue has room.
  always_comb begin
    res = '0;
    if (s1_pending[0]) begin
      lowest    = 3'b001;
      res.pixel = kern_value;
      res.row   = COORD_W'(s1_row - RW'(1));
      res.col   = COORD_W'(s1_col - CW'(1));
    end else if (s1_pending[1]) begin
      lowest    = 3'b010;
      res.pixel = mid_rd;
      res.row   = COORD_W'(s1_row - RW'(1));
      res.col   = COORD_W'(s1_col);
    end else begin
      lowest    = 3'b100;
      res.pixel = s1_pix;
      res.row   = COORD_W'(s1_row);
      res.col   = COORD_W'(s1_col);
    end
    rest           = s1_pending & ~lowest;
    res.last_item  = (rest == '0);
    res.last_frame = (rest == '0) && s1_frame_end;
  end

  assign push = s1_valid && (s1_pending != '0) && fifo_can_push;
  assign done = s1_valid && ((s1_pending == '0) || (push && (rest == '0)));

  vg3_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (res),
    .can_push   (fifo_can_push),
    .head_valid (fifo_valid),
    .pop        (m_axis_tready),
    .head       (head)
  );

  assign m_axis_tvalid = fifo_valid;
  assign m_axis_tdata  = {PAD_W'(0), head.col, head.row, head.pixel};
  assign m_axis_tuser  = head.last_item;
  assign m_axis_tlast  = head.last_frame;

  // ---------------------------------------------------------------- checks
  a_no_same_column : assert property (@(posedge clk) disable iff (rst)
    (done && accept) |-> (s1_col != col0))
    else $error("line store read and write hit the same column");

  a_pending_idle : assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> (s1_pending == '0))
    else $error("results pending with no pixel in flight");

  a_col_in_frame : assert property (@(posedge clk) disable iff (rst)
    $past(accept) |-> (col_count <= w_last))
    else $error("column counter left the frame after a pixel");

  a_frame_end_last : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("frame end on a result that is not the last of its pixel");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for vertical_gradient_3x3_filter: directed frames, then random
// frames against a predictor of the filter. Depends on vg3_pkg and the filter RTL only.
module tb
  import vg3_pkg::*;
();

  localparam int FRAME_MAX       = 1024;
  localparam int LINE_IDX_W      = $clog2(FRAME_MAX);
  localparam int RANDOM_PIXELS   = 200;
  // A pixel that causes no result may still be inside the filter when the queue of
  // expected results runs dry, so register writes wait this long beyond that point.
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_OFF_CYCLES = 100;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 60;

  localparam result_t NO_RESULT = '0;

  // One row of the directed script: a pixel request or a write of one size register.
  typedef enum logic [1:0] {STEP_PIXEL, STEP_WIDTH, STEP_HEIGHT} script_step_t;

  typedef struct packed {
    script_step_t     kind;
    logic [CFG_W-1:0] value;  // register value, or the pixel in the low bits
    logic             typed;  // want is the single result this pixel must cause
    result_t          want;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]       cfg_data = '0;

  // Shared between the sender, the receiver and the checker.
  logic    steady_stream = 1'b0;     // both sides stop idling while this is high
  logic    hold_off_request = 1'b0;  // asks the receiver for one long stall
  result_t expected_results [$];
  int      mismatches = 0;
  int      quiet_cycles = 0;

  // Predictor state: the size registers as written, both line stores, the neighbourhood
  // window and the raster position of the next pixel.
  logic [CFG_W-1:0] width_setting  = CFG_W'(CFG_RESET);
  logic [CFG_W-1:0] height_setting = CFG_W'(CFG_RESET);
  logic [PIX_W-1:0] line_prev     [FRAME_MAX] = '{default: '0};
  logic [PIX_W-1:0] line_two_back [FRAME_MAX] = '{default: '0};
  window_t          nbhd = '0;
  int unsigned      row_cnt = 0;
  int unsigned      col_cnt = 0;

  // Directed script. Row-0 pixels pass through untouched, so their results are typed
  // in; everything else is left to the predictor.
  //   - Four pixels of row 0 at the reset width of 1024, with both extreme values.
  //   - Width 2 (saturates to 3) shrinks the frame mid-row: the column counter is beyond
  //     the new width, so the next pixel starts row 1. Height 0 saturates to 3.
  //   - Row 1 causes nothing; the last row clamps its interior result high and emits
  //     three results on its final pixel, the last one closing the frame.
  //   - A 3x4 frame whose row 2 starts with a pixel that causes nothing and whose
  //     interior clamps low.
  //   - Width all ones (saturates to the maximum) and height 1024 at the frame boundary.
  script_row_t script [29] = '{
    '{STEP_PIXEL,  11'h000, 1'b1, '{1'b0, 1'b1, 10'd0, 10'd0, 8'h00}},
    '{STEP_PIXEL,  11'h0FF, 1'b1, '{1'b0, 1'b1, 10'd1, 10'd0, 8'hFF}},
    '{STEP_PIXEL,  11'h0A5, 1'b1, '{1'b0, 1'b1, 10'd2, 10'd0, 8'hA5}},
    '{STEP_PIXEL,  11'h05A, 1'b1, '{1'b0, 1'b1, 10'd3, 10'd0, 8'h5A}},
    '{STEP_WIDTH,  11'd2,   1'b0, NO_RESULT},
    '{STEP_HEIGHT, 11'd0,   1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h080, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h001, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h0FE, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h0FF, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h0FF, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h0FF, 1'b0, NO_RESULT},
    '{STEP_HEIGHT, 11'd4,   1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h0FF, 1'b1, '{1'b0, 1'b1, 10'd0, 10'd0, 8'hFF}},
    '{STEP_PIXEL,  11'h0FF, 1'b1, '{1'b0, 1'b1, 10'd1, 10'd0, 8'hFF}},
    '{STEP_PIXEL,  11'h0FF, 1'b1, '{1'b0, 1'b1, 10'd2, 10'd0, 8'hFF}},
    '{STEP_PIXEL,  11'h010, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h07F, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h033, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h000, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h000, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h000, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h000, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h080, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h000, 1'b0, NO_RESULT},
    '{STEP_WIDTH,  11'h7FF, 1'b0, NO_RESULT},
    '{STEP_HEIGHT, 11'd1024, 1'b0, NO_RESULT},
    '{STEP_PIXEL,  11'h03C, 1'b1, '{1'b0, 1'b1, 10'd0, 10'd0, 8'h3C}},
    '{STEP_PIXEL,  11'h0C3, 1'b1, '{1'b0, 1'b1, 10'd1, 10'd0, 8'hC3}}
  };

  vertical_gradient_3x3_filter #(
    .MAX_WIDTH (FRAME_MAX),
    .MAX_HEIGHT(FRAME_MAX)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // pixel [7:0]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // out_pixel [7:0], out_row [17:8], out_col [27:18]
    .m_axis_tuser (m_axis_tuser),   // last_of_item
    .m_axis_tlast (m_axis_tlast),   // last_of_frame
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // The filter saturates both sizes into the range from the minimum to the maximum.
  function automatic int unsigned effective_size(input logic [CFG_W-1:0] v);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > FRAME_MAX) return FRAME_MAX;
    return 32'(v);
  endfunction

  // Advances the predictor by one pixel and returns the results it causes, in the order
  // the filter emits them: the interior or left-border result one column back, the
  // right-border result of the row above, then the pass-through of a first or last row.
  function automatic int predict_pixel(input logic [PIX_W-1:0] pix,
                                       output result_t produced [3]);
    int unsigned      w, h, row, col;
    logic [PIX_W-1:0] top, mid, level;
    int               sum, n;
    w = effective_size(width_setting);
    h = effective_size(height_setting);
    n = 0;
    produced = '{default: NO_RESULT};

    // A size shrunk since the last pixel can leave the position outside the frame.
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    row = row_cnt;
    col = col_cnt;
    top = line_two_back[col[LINE_IDX_W-1:0]];
    mid = line_prev[col[LINE_IDX_W-1:0]];

    if (row >= 2 && col >= 1) begin
      if (col == 1) begin
        // Column 0 of the row above is a border pixel and passes through.
        level = nbhd.mid_near;
      end else begin
        sum = KW_SIDE * (int'(nbhd.bot_far) + int'(pix)) + int'(nbhd.bot_near)
            - KW_SIDE * (int'(nbhd.top_far) + int'(top)) - int'(nbhd.top_near);
        if (sum < 0) sum = 0;
        else if (sum > PIX_MAX) sum = PIX_MAX;
        level = PIX_W'(sum);
      end
      produced[2'(n)] = '{1'b0, 1'b0, COORD_W'(col - 1), COORD_W'(row - 1), level};
      n++;
    end
    if (row >= 2 && col == w - 1) begin
      produced[2'(n)] = '{1'b0, 1'b0, COORD_W'(col), COORD_W'(row - 1), mid};
      n++;
    end
    if (row == 0 || row == h - 1) begin
      produced[2'(n)] = '{1'b0, 1'b0, COORD_W'(col), COORD_W'(row), pix};
      n++;
    end

    line_two_back[col[LINE_IDX_W-1:0]] = mid;
    line_prev[col[LINE_IDX_W-1:0]]     = pix;
    nbhd.top_far  = nbhd.top_near;
    nbhd.top_near = top;
    nbhd.mid_near = mid;
    nbhd.bot_far  = nbhd.bot_near;
    nbhd.bot_near = pix;

    if (n > 0) begin
      produced[2'(n - 1)].last_item = 1'b1;
      if (row == h - 1 && col == w - 1) produced[2'(n - 1)].last_frame = 1'b1;
    end

    col_cnt = col + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = row + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
    return n;
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one pixel request and holds it until the filter takes it. Now and then a
  // single idle cycle goes before the request. A typed row replaces the predicted
  // results by the one written in the script; the predictor still steps either way.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                            input result_t want);
    result_t produced [3];
    int      n;
    if (!steady_stream && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk); while (!s_axis_tready);
    n = predict_pixel(pix, produced);
    if (typed) expected_results.push_back(want);
    else for (int k = 0; k < n; k++) expected_results.push_back(produced[2'(k)]);
  endtask

  // Stops offering pixels and waits until the filter has nothing left in flight.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One write, followed by a quiet cycle so that writes back to back never drive the
  // enable twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_setting = value;
    else height_setting = value;
    @(posedge clk);
  endtask

  // Stimulus. A width may shrink at any point of a frame, but it only grows at the start
  // of one: rows 0 and 1 must fill the line stores across the new width before any row
  // reads them, or the filter would read entries that were never written.
  initial begin : pixel_sender
    int               random_sent, run_len, k;
    bit               to_frame_end;
    logic [PIX_W-1:0] pix;
    logic [CFG_W-1:0] new_size;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      case (script[i].kind)
        STEP_PIXEL: send_pixel(script[i].value[PIX_W-1:0], script[i].typed, script[i].want);
        STEP_WIDTH: begin
          settle();
          write_reg(REG_IMAGE_WIDTH, script[i].value);
        end
        STEP_HEIGHT: begin
          settle();
          write_reg(REG_IMAGE_HEIGHT, script[i].value);
        end
        default: ;
      endcase
    end

    // Random frames. The first run is long and meets the receiver's long stall, so the
    // filter fills up and holds its input. Some runs stop exactly at a frame boundary,
    // which is where a wider frame may start; every run ends with the sender waiting
    // for all expected results before the sizes are changed.
    hold_off_request <= 1'b1;
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      to_frame_end = ($urandom_range(2) == 0);
      run_len = (random_sent == 0) ? 40 : to_frame_end ? 80 : $urandom_range(5, 40);
      for (k = 0; k < run_len && random_sent < RANDOM_PIXELS; k++) begin
        steady_stream <= (random_sent >= 80 && random_sent < 140);
        case ($urandom_range(7))
          0:       pix = '0;
          1:       pix = '1;
          default: pix = PIX_W'($urandom_range(PIX_MAX));
        endcase
        send_pixel(pix, 1'b0, NO_RESULT);
        random_sent++;
        if (to_frame_end && row_cnt == 0 && col_cnt == 0) break;
      end
      settle();

      // Mostly narrow frames, so that rows past the second come often; a wide frame always
      // has a new width drawn at the next pause, and that width is mostly a narrow one.
      if (effective_size(width_setting) > 9 || $urandom_range(1) == 1) begin
        case ($urandom_range(19))
          0:       new_size = '1;
          1:       new_size = CFG_W'(FRAME_MAX);
          2:       new_size = CFG_W'($urandom_range(MIN_SIZE - 1));
          default: new_size = CFG_W'($urandom_range(MIN_SIZE, 9));
        endcase
        if (effective_size(new_size) <= effective_size(width_setting) ||
            (row_cnt == 0 && col_cnt == 0))
          write_reg(REG_IMAGE_WIDTH, new_size);
      end
      // A height below the current row sends the next pixel back to row 0.
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(19))
          0:       new_size = CFG_W'($urandom_range(FRAME_MAX + 1, 2047));
          1:       new_size = CFG_W'(FRAME_MAX);
          2:       new_size = CFG_W'($urandom_range(MIN_SIZE - 1));
          default: new_size = CFG_W'($urandom_range(MIN_SIZE, 7));
        endcase
        write_reg(REG_IMAGE_HEIGHT, new_size);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[vertical_gradient_3x3_filter] OK");
    end else begin
      $display("[vertical_gradient_3x3_filter] ERROR");
    end
    $finish;
  end

  // Receiver: idles now and then, never while the stream is meant to be steady, and once
  // refuses results for a long stretch so that the filter backs up into its input.
  initial begin : result_receiver
    int hold_left;
    bit hold_off_done;
    hold_left = 0;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request && !hold_off_done) begin
        hold_off_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (steady_stream) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 6);
      end
    end
  end

  // Each accepted result must match the oldest expectation, field by field.
  always @(posedge clk) begin : result_checker
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result with none expected, actual pixel %0d row %0d col %0d",
                   $time, m_axis_tdata[PIX_W-1:0], m_axis_tdata[PIX_W +: COORD_W],
                   m_axis_tdata[PIX_W + COORD_W +: COORD_W]);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        compare_field("out_pixel", int'(want.pixel), int'(m_axis_tdata[PIX_W-1:0]));
        compare_field("out_row", int'(want.row), int'(m_axis_tdata[PIX_W +: COORD_W]));
        compare_field("out_col", int'(want.col),
                      int'(m_axis_tdata[PIX_W + COORD_W +: COORD_W]));
        compare_field("last_of_item", int'(want.last_item), int'(m_axis_tuser));
        compare_field("last_of_frame", int'(want.last_frame), int'(m_axis_tlast));
      end
    end
  end

  // Ends a run in which neither side has moved a request for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[vertical_gradient_3x3_filter] ERROR");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
rtl/vg3_pkg.sv
rtl/vg3_line_ram.sv
rtl/vg3_kernel.sv
rtl/vg3_out_fifo.sv
rtl/vertical_gradient_3x3_filter.sv
tb/sv/tb.sv
